// ----- rtl/lzsbd_pkg.sv -----
// Shared types and constants of the LZSS bit-stream decoder.
package lzsbd_pkg;

    localparam int DEF_HISTORY_DEPTH = 8192;
    localparam int DEF_POSITION_BITS = 13;
    localparam int DEF_LENGTH_BITS   = 4;

    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 24;
    localparam int LEN_BIAS = 3;
    // A literal token is the flag bit and eight data bits.
    localparam int LIT_BITS = 1 + BYTE_W;

    // Configuration port: byte addresses are 4*i, paddr covers one spare word.
    localparam int   PADDR_W = 3;
    localparam int   PDATA_W = 32;
    localparam logic REG_MAX_OUTPUT_LENGTH = 1'b0;

    // Requests from the sequencer to the output stage.
    typedef struct packed {
        logic              emit;
        logic              flush;
        logic              done;
        logic [BYTE_W-1:0] data;
    } out_cmd_t;

    // Status of the output stage seen by the sequencer.
    typedef struct packed {
        logic              pend_valid;
        logic              out_free;
        logic [BYTE_W-1:0] pend_byte;
    } out_sts_t;

endpackage

// ----- rtl/lzsbd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module lzsbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/lzsbd_out.sv -----
// Output stage: holds the newest result until its run flags are known, then registers it.
module lzsbd_out
    import lzsbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  out_cmd_t          cmd,
    output out_sts_t          sts,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              byte_valid,
    output logic              last_of_run,
    output logic              stream_done
);

    logic              pv_reg, pv_next;
    logic [BYTE_W-1:0] pbyte_reg, pbyte_next;
    logic              ov_reg, ov_next;
    logic [BYTE_W-1:0] obyte_reg, obyte_next;
    logic              obv_reg, obv_next;
    logic              olast_reg, olast_next;
    logic              odone_reg, odone_next;
    logic              out_free;

    assign out_free = !ov_reg || !out_stall;

    always_comb
    begin
        pv_next    = pv_reg;
        pbyte_next = pbyte_reg;
        ov_next    = ov_reg;
        obyte_next = obyte_reg;
        obv_next   = obv_reg;
        olast_next = olast_reg;
        odone_next = odone_reg;
        if (out_free)
        begin
            ov_next = 1'b0;
        end
        if (cmd.emit)
        begin
            if (pv_reg)
            begin
                ov_next    = 1'b1;
                obyte_next = pbyte_reg;
                obv_next   = 1'b1;
                olast_next = 1'b0;
                odone_next = 1'b0;
            end
            pv_next    = 1'b1;
            pbyte_next = cmd.data;
        end
        if (cmd.flush)
        begin
            if (pv_reg)
            begin
                ov_next    = 1'b1;
                obyte_next = pbyte_reg;
                obv_next   = 1'b1;
                olast_next = 1'b1;
                odone_next = cmd.done;
                pv_next    = 1'b0;
            end
            else if (cmd.done)
            begin
                // The stream ended in an item that produced no data.
                ov_next    = 1'b1;
                obyte_next = '0;
                obv_next   = 1'b0;
                olast_next = 1'b1;
                odone_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= pv_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pbyte_reg <= pbyte_next;
        obyte_reg <= obyte_next;
        obv_reg   <= obv_next;
        olast_reg <= olast_next;
        odone_reg <= odone_next;
    end

    assign sts.pend_valid = pv_reg;
    assign sts.out_free   = out_free;
    assign sts.pend_byte  = pbyte_reg;

    assign out_valid   = ov_reg;
    assign out_byte    = obyte_reg;
    assign byte_valid  = obv_reg;
    assign last_of_run = olast_reg;
    assign stream_done = odone_reg;

endmodule

// ----- rtl/lzsbd_core.sv -----
// Token parser and match sequencer around the history RAM.
module lzsbd_core
    import lzsbd_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int POSITION_BITS = DEF_POSITION_BITS,
    parameter int LENGTH_BITS   = DEF_LENGTH_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic               new_stream,
    input  logic               last_in,
    input  logic [LIMIT_W-1:0] max_output_length,
    output out_cmd_t           out_cmd,
    input  out_sts_t           out_sts
);

    localparam int AW      = $clog2(HISTORY_DEPTH);
    localparam int TOK_W   = 1 + POSITION_BITS + LENGTH_BITS;
    localparam int CNT_W   = $clog2(TOK_W + 1);
    localparam int POS_CNT = 1 + POSITION_BITS;
    localparam int MLEN_W  = LENGTH_BITS + 1;

    localparam int         ST_W     = 3;
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BITS  = 3'd1;
    localparam logic [2:0] ST_MRD   = 3'd2;
    localparam logic [2:0] ST_MEM   = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [ST_W-1:0]    state_reg, state_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic [2:0]         bidx_reg, bidx_next;
    logic               last_reg, last_next;
    logic [TOK_W-1:0]   tok_reg, tok_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               flag_reg, flag_next;
    logic [AW-1:0]      wp_reg, wp_next;
    logic               wrapped_reg, wrapped_next;
    logic [LIMIT_W-1:0] outcnt_reg, outcnt_next;
    logic               fin_reg, fin_next;
    logic [AW-1:0]      mraddr_reg, mraddr_next;
    logic [MLEN_W-1:0]  mrem_reg, mrem_next;
    logic               ret_flush_reg, ret_flush_next;
    logic               rd_ok_reg, rd_ok_next;
    logic               fwd_reg, fwd_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;

    logic                     bit_now;
    logic [TOK_W-1:0]         tok_new;
    logic [CNT_W-1:0]         cnt_new;
    logic                     flag_now;
    logic [POSITION_BITS-1:0] match_pos;
    logic [LENGTH_BITS-1:0]   match_len;
    logic [LIMIT_W-1:0]       outcnt_inc;
    logic                     emit_fin;
    logic [BYTE_W-1:0]        mem_byte;
    logic [AW-1:0]            rd_next;
    logic                     fin_start;
    logic [LIMIT_W-1:0]       outcnt_start;
    logic                     fin_eff;
    logic                     can_emit;
    logic                     flush_ok;
    logic                     emit;
    logic [BYTE_W-1:0]        emit_byte;

    lzsbd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign bit_now    = byte_reg[bidx_reg];
    assign tok_new    = {tok_reg[TOK_W-2:0], bit_now};
    assign cnt_new    = cnt_reg + CNT_W'(1);
    assign flag_now   = (cnt_reg == '0) ? bit_now : flag_reg;
    assign match_pos  = tok_new[LENGTH_BITS +: POSITION_BITS];
    assign match_len  = tok_new[LENGTH_BITS-1:0];
    assign outcnt_inc = outcnt_reg + LIMIT_W'(1);
    assign emit_fin   = outcnt_inc >= max_output_length;
    assign rd_next    = mraddr_reg + AW'(1);

    // Entries beyond the fill count of this stream read as zero; a read that
    // hit the entry written in the same cycle takes the byte just emitted.
    assign mem_byte = fwd_reg ? out_sts.pend_byte : (rd_ok_reg ? ram_rdata : '0);

    assign fin_start    = fin_reg && !new_stream;
    assign outcnt_start = new_stream ? '0 : outcnt_reg;
    assign fin_eff      = fin_reg || last_reg;
    assign can_emit     = !out_sts.pend_valid || out_sts.out_free;
    assign flush_ok     = out_sts.out_free || (!out_sts.pend_valid && !fin_eff);

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        bidx_next      = bidx_reg;
        last_next      = last_reg;
        tok_next       = tok_reg;
        cnt_next       = cnt_reg;
        flag_next      = flag_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        outcnt_next    = outcnt_reg;
        fin_next       = fin_reg;
        mraddr_next    = mraddr_reg;
        mrem_next      = mrem_reg;
        ret_flush_next = ret_flush_reg;
        rd_ok_next     = rd_ok_reg;
        fwd_next       = fwd_reg;
        ram_re         = 1'b0;
        ram_raddr      = mraddr_reg;
        emit           = 1'b0;
        emit_byte      = '0;
        out_cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (new_stream)
                    begin
                        wp_next      = '0;
                        wrapped_next = 1'b0;
                        tok_next     = '0;
                        cnt_next     = '0;
                        outcnt_next  = '0;
                        fin_next     = 1'b0;
                    end
                    byte_next = in_byte;
                    bidx_next = 3'd7;
                    last_next = last_in;
                    if (!fin_start)
                    begin
                        if (outcnt_start >= max_output_length)
                        begin
                            fin_next   = 1'b1;
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            state_next = ST_BITS;
                        end
                    end
                end
            end
            ST_BITS:
            begin
                flag_next = flag_now;
                if (flag_now && cnt_new == CNT_W'(LIT_BITS))
                begin
                    if (can_emit)
                    begin
                        emit      = 1'b1;
                        emit_byte = tok_new[BYTE_W-1:0];
                        tok_next  = '0;
                        cnt_next  = '0;
                        if (emit_fin)
                        begin
                            fin_next   = 1'b1;
                            state_next = ST_FLUSH;
                        end
                        else if (bidx_reg == '0)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            bidx_next = bidx_reg - 3'd1;
                        end
                    end
                end
                else if (!flag_now && cnt_new == CNT_W'(POS_CNT)
                         && tok_new[POSITION_BITS-1:0] == '0)
                begin
                    // End marker: the rest of the item is dropped.
                    fin_next   = 1'b1;
                    tok_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_FLUSH;
                end
                else if (!flag_now && cnt_new == CNT_W'(TOK_W))
                begin
                    tok_next       = '0;
                    cnt_next       = '0;
                    mraddr_next    = AW'(match_pos - POSITION_BITS'(1));
                    mrem_next      = MLEN_W'(match_len) + MLEN_W'(LEN_BIAS);
                    ret_flush_next = (bidx_reg == '0);
                    bidx_next      = bidx_reg - 3'd1;
                    state_next     = ST_MRD;
                end
                else
                begin
                    tok_next = tok_new;
                    cnt_next = cnt_new;
                    if (bidx_reg == '0)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        bidx_next = bidx_reg - 3'd1;
                    end
                end
            end
            ST_MRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = mraddr_reg;
                rd_ok_next = wrapped_reg || (mraddr_reg < wp_reg);
                fwd_next   = 1'b0;
                state_next = ST_MEM;
            end
            ST_MEM:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    emit_byte = mem_byte;
                    if (emit_fin)
                    begin
                        // Length limit reached inside the match: truncate it.
                        fin_next   = 1'b1;
                        state_next = ST_FLUSH;
                    end
                    else if (mrem_reg == MLEN_W'(1))
                    begin
                        state_next = ret_flush_reg ? ST_FLUSH : ST_BITS;
                    end
                    else
                    begin
                        mrem_next   = mrem_reg - MLEN_W'(1);
                        mraddr_next = rd_next;
                        ram_re      = 1'b1;
                        ram_raddr   = rd_next;
                        rd_ok_next  = wrapped_reg || (rd_next <= wp_reg);
                        fwd_next    = (rd_next == wp_reg);
                    end
                end
            end
            ST_FLUSH:
            begin
                out_cmd.done = fin_eff;
                if (flush_ok)
                begin
                    out_cmd.flush = 1'b1;
                    fin_next      = fin_eff;
                    if (fin_eff)
                    begin
                        tok_next = '0;
                        cnt_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            wp_next      = wp_reg + AW'(1);
            wrapped_next = wrapped_reg || (wp_reg == AW'(HISTORY_DEPTH - 1));
            outcnt_next  = outcnt_inc;
            out_cmd.emit = 1'b1;
            out_cmd.data = emit_byte;
        end
    end

    assign ram_we    = emit;
    assign ram_waddr = wp_reg;
    assign ram_wdata = emit_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            byte_reg      <= '0;
            bidx_reg      <= '0;
            last_reg      <= 1'b0;
            tok_reg       <= '0;
            cnt_reg       <= '0;
            flag_reg      <= 1'b0;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            outcnt_reg    <= '0;
            fin_reg       <= 1'b0;
            mraddr_reg    <= '0;
            mrem_reg      <= '0;
            ret_flush_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_reg      <= byte_next;
            bidx_reg      <= bidx_next;
            last_reg      <= last_next;
            tok_reg       <= tok_next;
            cnt_reg       <= cnt_next;
            flag_reg      <= flag_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            outcnt_reg    <= outcnt_next;
            fin_reg       <= fin_next;
            mraddr_reg    <= mraddr_next;
            mrem_reg      <= mrem_next;
            ret_flush_reg <= ret_flush_next;
            rd_ok_reg     <= rd_ok_next;
            fwd_reg       <= fwd_next;
        end
    end

endmodule

// ----- rtl/lzss_bit_stream_decoder_top.sv -----
// Top level of the LZSS bit-stream decoder: configuration port, sequencer and output stage.
//
// The decoder takes one compressed item (a byte) at a time and reads it most
// significant bit first, one bit per clock while no match is being copied and
// the output does not stall. A 1 flag bit opens an 8-bit literal; a 0 flag
// opens an absolute history position and a length, and the match copies
// length+3 bytes from the history ring, one byte per clock from the history
// RAM while the output does not stall, after a first read has been issued.
// Position 0 ends the stream. A new item is taken only once the previous one
// has been flushed and the sequencer is idle again. The history is not cleared
// by a sweep: a fill count of the current stream makes unwritten entries read
// as zero, so a new stream starts at once and there is no clearing pass after
// reset. HISTORY_DEPTH must be a power of two. Every result item carries
// last_of_run on the final result of its input item, and stream_done there
// when the stream finished; a stream that ends in an item that produced no
// data gives one status item with byte_valid low. max_output_length sits at
// byte address 0 of the configuration port; the user must write it only while
// the block is idle, and the block itself does not enforce this.
module lzss_bit_stream_decoder_top
    import lzsbd_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int POSITION_BITS = DEF_POSITION_BITS,
    parameter int LENGTH_BITS   = DEF_LENGTH_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Compressed input items.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic               new_stream,
    input  logic               last_in,
    // Result items.
    output logic               out_valid,
    input  logic               out_stall,
    output logic [BYTE_W-1:0]  out_byte,
    output logic               byte_valid,
    output logic               last_of_run,
    output logic               stream_done
);

    logic [LIMIT_W-1:0] max_len_reg, max_len_next;
    logic               cfg_write;
    out_cmd_t           out_cmd;
    out_sts_t           out_sts;

    // The port never waits, so a write lands in its access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        max_len_next = max_len_reg;
        if (cfg_write && paddr[PADDR_W-1] == REG_MAX_OUTPUT_LENGTH)
        begin
            max_len_next = pwdata[LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_MAX_OUTPUT_LENGTH)
        begin
            prdata = PDATA_W'(max_len_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= '0;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    // The sequencer parses tokens and walks matches through the history RAM.
    lzsbd_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .in_byte           (in_byte),
        .new_stream        (new_stream),
        .last_in           (last_in),
        .max_output_length (max_len_reg),
        .out_cmd           (out_cmd),
        .out_sts           (out_sts)
    );

    // The output stage keeps the newest byte back until it is known whether
    // it closes the run of its input item.
    lzsbd_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (out_cmd),
        .sts         (out_sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last_of_run (last_of_run),
        .stream_done (stream_done)
    );

`ifndef ASSERT_OFF
    // A status-only result always closes its run and the stream.
    a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last_of_run && stream_done && out_byte == '0)
        else $error("status item without run and stream end flags");

    // The stream can only finish on the final result of an input item.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_done |-> last_of_run)
        else $error("stream_done on a result that does not close its run");

    // A result is never shown while its input item is still being taken in.
    a_no_item_in_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall || !out_valid || $past(out_valid))
        else $error("result appeared without work on an item");
`endif

endmodule

// ----- test/tb_lzss_bit_stream_decoder_top.sv -----
// Self-checking testbench for the LZSS bit-stream decoder top level.
module tb_lzss_bit_stream_decoder_top;
    import lzsbd_pkg::*;

    // Decoder geometry, taken from the package defaults that the instance uses.
    localparam int HIST_DEPTH = DEF_HISTORY_DEPTH;
    localparam int HIST_AW    = $clog2(DEF_HISTORY_DEPTH);
    localparam int POS_W      = DEF_POSITION_BITS;
    localparam int LEN_W      = DEF_LENGTH_BITS;
    localparam int TOKEN_W    = 1 + POS_W + LEN_W;
    localparam int MATCH_MAX  = (1 << LEN_W) - 1;

    // Token flag values as they appear in the bit stream.
    localparam bit FLAG_LITERAL = 1'b1;
    localparam bit FLAG_MATCH   = 1'b0;

    localparam logic [PADDR_W-1:0] ADDR_MAX_OUTPUT_LENGTH = {REG_MAX_OUTPUT_LENGTH, 2'b00};
    localparam logic [LIMIT_W-1:0] LIMIT_MAX              = '1;

    // Timing budget. After the last expected result we allow SETTLE_CYCLES before
    // touching the configuration. The cycle limit covers every item at its worst
    // under heavy stalls.
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PRINT_CAP     = 30;

    // Items queued per limit setting, and the point where the sender waits.
    localparam int ITEMS_PER_SETTING = 12;
    localparam int PAUSE_AFTER       = 6;

    // One compressed item as offered on the input channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
        logic              last;
    } compressed_t;

    // One result item as it leaves the decoder.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              run_end;
        logic              done;
    } decoded_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] in_byte = '0;
    logic              new_stream = 1'b0;
    logic              last_in = 1'b0;

    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last_of_run;
    logic              stream_done;

    lzss_bit_stream_decoder_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .new_stream  (new_stream),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last_of_run (last_of_run),
        .stream_done (stream_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder predictor. This is an independent copy of the decoder state:
    // history ring, write pointer, partial token, output count, finished flag
    // and the configured length limit.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0]  hist [HIST_DEPTH];
    logic [HIST_AW-1:0] wr_ptr;
    logic [TOKEN_W-1:0] tok_bits;
    logic [4:0]         tok_cnt;
    logic [LIMIT_W-1:0] out_cnt;
    logic [LIMIT_W-1:0] out_limit;
    logic               dec_done;

    decoded_t    run_q[$];       // results of the item being decoded
    decoded_t    decoded_q[$];   // results still awaited from the block
    compressed_t compressed_q[$]; // items waiting to be offered
    bit          bit_q[$];       // bit stream being assembled by the encoder

    int error_count = 0;
    int items_taken = 0;
    int results_seen = 0;
    int streams_seen = 0;

    // Clears the decoder state, as a stream start does.
    function automatic void restart_stream();
        for (int i = 0; i < HIST_DEPTH; i++)
            hist[i] = '0;
        wr_ptr   = '0;
        tok_bits = '0;
        tok_cnt  = '0;
        out_cnt  = '0;
        dec_done = 1'b0;
    endfunction

    // Every decoded byte goes out, into the ring, and counts toward the limit.
    function automatic void emit_byte(input logic [BYTE_W-1:0] b);
        decoded_t r;
        r.data    = b;
        r.valid   = 1'b1;
        r.run_end = 1'b0;
        r.done    = 1'b0;
        run_q.push_back(r);
        hist[wr_ptr] = b;
        wr_ptr  = wr_ptr + 1'b1;
        out_cnt = out_cnt + 1'b1;
        if (out_cnt >= out_limit)
            dec_done = 1'b1;
    endfunction

    // Shifts one stream bit into the token and acts once the token is complete.
    function automatic void take_bit(input logic b_in);
        logic [POS_W-1:0] pos;
        int               len;
        int               idx;
        tok_bits = {tok_bits[TOKEN_W-2:0], b_in};
        tok_cnt  = tok_cnt + 1'b1;
        if (tok_bits[tok_cnt-1] == FLAG_LITERAL)
        begin
            if (tok_cnt == LIT_BITS)
            begin
                emit_byte(tok_bits[BYTE_W-1:0]);
                tok_bits = '0;
                tok_cnt  = '0;
            end
        end
        else if (tok_cnt == 1 + POS_W)
        begin
            // An all-zero position is the end marker.
            if (tok_bits[POS_W-1:0] == '0)
            begin
                dec_done = 1'b1;
                tok_bits = '0;
                tok_cnt  = '0;
            end
        end
        else if (tok_cnt == TOKEN_W)
        begin
            len      = int'(tok_bits[LEN_W-1:0]) + LEN_BIAS;
            pos      = tok_bits[LEN_W +: POS_W];
            tok_bits = '0;
            tok_cnt  = '0;
            for (int i = 0; i < len && !dec_done; i++)
            begin
                idx = (int'(pos) + i - 1) % HIST_DEPTH;
                emit_byte(hist[idx]);
            end
        end
    endfunction

    // Works out the results of one accepted item and queues them as expected.
    function automatic void decode_item(input compressed_t it);
        decoded_t status;
        run_q.delete();
        if (it.start)
            restart_stream();
        if (dec_done)
            return;
        if (out_cnt >= out_limit)
            dec_done = 1'b1;
        else
            for (int k = BYTE_W - 1; k >= 0 && !dec_done; k--)
                take_bit(it.data[k]);
        if (it.last)
            dec_done = 1'b1;
        if (dec_done)
        begin
            // A partial token is dropped; a stream ending without data still reports.
            tok_bits = '0;
            tok_cnt  = '0;
            if (run_q.size() == 0)
            begin
                status = '0;
                run_q.push_back(status);
            end
            run_q[run_q.size()-1].done = 1'b1;
        end
        if (run_q.size() != 0)
            run_q[run_q.size()-1].run_end = 1'b1;
        foreach (run_q[i])
            decoded_q.push_back(run_q[i]);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("ERROR @%0t: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------
    // Monitor. All sampling happens at the rising edge; inputs only move at the
    // falling edge, so the values seen here are the ones the block latched.
    // The result check runs before the new item is decoded so that ordering is
    // never in doubt.
    // ------------------------------------------------------------------
    logic in_acc = 1'b0;

    always @(posedge clk)
    begin : result_monitor
        decoded_t got;
        decoded_t want;
        compressed_t seen;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.data    = out_byte;
                got.valid   = byte_valid;
                got.run_end = last_of_run;
                got.done    = stream_done;
                results_seen++;
                if (decoded_q.size() == 0)
                begin
                    report_mismatch($sformatf(
                        "unexpected result byte=%02h valid=%b last=%b done=%b",
                        got.data, got.valid, got.run_end, got.done));
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "result byte=%02h valid=%b last=%b done=%b, want %02h %b %b %b",
                            got.data, got.valid, got.run_end, got.done,
                            want.data, want.valid, want.run_end, want.done));
                end
            end
            if (in_valid && !in_stall)
            begin
                seen.data  = in_byte;
                seen.start = new_stream;
                seen.last  = last_in;
                items_taken++;
                if (new_stream)
                    streams_seen++;
                decode_item(seen);
            end
        end
        in_acc <= rst_n && in_valid && !in_stall;
    end

    // ------------------------------------------------------------------
    // Input driver. A new item is only put up after the previous one was
    // taken; the choice to idle is random and never looks at in_stall.
    // ------------------------------------------------------------------
    int send_gap_pct = 0;
    int recv_gap_pct = 0;

    always @(negedge clk)
    begin : item_driver
        compressed_t cur;
        if (rst_n && (!in_valid || in_acc))
        begin
            if (compressed_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                cur = compressed_q.pop_front();
                in_valid   <= 1'b1;
                in_byte    <= cur.data;
                new_stream <= cur.start;
                last_in    <= cur.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output back-pressure. Besides random stalls, a long hold can be requested
    // by the main sequence; it is counted down here, one cycle per clock, while
    // the input side keeps offering items so that the decoder backs up.
    // ------------------------------------------------------------------
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    always @(negedge clk)
    begin : stall_driver
        if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_gap_pct);
        end
    end

    // Watchdog on the whole run.
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                cycle_count, decoded_q.size());
            $display("lzss_bit_stream_decoder_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Configuration access.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Sets the length limit in the block and in the predictor, then reads it back.
    task automatic set_limit(input logic [LIMIT_W-1:0] limit);
        logic [PDATA_W-1:0] rd;
        apb_write(ADDR_MAX_OUTPUT_LENGTH, PDATA_W'(limit));
        out_limit = limit;
        apb_read(ADDR_MAX_OUTPUT_LENGTH, rd);
        if (rd !== PDATA_W'(limit))
            report_mismatch($sformatf("max_output_length reads %0h, wrote %0h", rd, limit));
    endtask

    // Waits until every item is taken and every result has come back, then
    // gives an item that produces no result time to finish inside the block.
    task automatic wait_idle();
        @(posedge clk);
        while (compressed_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stream encoder: tokens are appended as bits, then packed MSB first.
    // ------------------------------------------------------------------
    task automatic put_bits(input int unsigned val, input int n);
        for (int k = n - 1; k >= 0; k--)
            bit_q.push_back(val[k]);
    endtask

    task automatic put_literal(input int unsigned b);
        put_bits(FLAG_LITERAL, 1);
        put_bits(b, BYTE_W);
    endtask

    task automatic put_match(input int unsigned pos, input int unsigned len_code);
        put_bits(FLAG_MATCH, 1);
        put_bits(pos, POS_W);
        put_bits(len_code, LEN_W);
    endtask

    task automatic put_end_marker();
        put_bits(FLAG_MATCH, 1);
        put_bits(0, POS_W);
    endtask

    task automatic queue_item(input int unsigned data, input bit start, input bit last);
        compressed_t it;
        it.data  = data[BYTE_W-1:0];
        it.start = start;
        it.last  = last;
        compressed_q.push_back(it);
    endtask

    // Packs the assembled bits into items; the first one opens a stream and the
    // tail of the last one is padded with random bits.
    task automatic flush_stream(input bit mark_last, output int n_items);
        logic [BYTE_W-1:0] b;
        while (bit_q.size() % BYTE_W != 0)
            bit_q.push_back(1'($urandom_range(1)));
        n_items = bit_q.size() / BYTE_W;
        for (int i = 0; i < n_items; i++)
        begin
            for (int k = BYTE_W - 1; k >= 0; k--)
                b[k] = bit_q.pop_front();
            queue_item(b, i == 0, mark_last && i == n_items - 1);
        end
    endtask

    // A well-formed stream with random content: literals and matches that
    // mostly point back into bytes already written, with one of four endings.
    task automatic queue_random_stream(output int n_items);
        int n_tok;
        int written;
        int len_code;
        int pos;
        int ending;
        n_tok   = $urandom_range(8, 1);
        written = 0;
        bit_q.delete();
        for (int t = 0; t < n_tok; t++)
        begin
            if ($urandom_range(99) < 55)
            begin
                put_literal($urandom_range(255));
                written++;
            end
            else
            begin
                len_code = $urandom_range(MATCH_MAX);
                if (written > 0 && $urandom_range(9) < 7)
                    pos = $urandom_range(written, 1);
                else
                    pos = $urandom_range(HIST_DEPTH - 1, 1);
                put_match(pos, len_code);
                written += len_code + LEN_BIAS;
            end
        end
        // Ending: an end marker, the input-end flag, both, or neither (the next
        // stream start cuts it off).
        ending = $urandom_range(9);
        if (ending < 4)
            put_end_marker();
        flush_stream(ending >= 2 && ending < 8, n_items);
    endtask

    // Raw bytes with random flags: broken tokens, stray starts and bytes that
    // arrive after a stream has finished.
    task automatic queue_noise(output int n_items);
        n_items = $urandom_range(3, 1);
        for (int i = 0; i < n_items; i++)
            queue_item($urandom_range(255),
                i == 0 ? $urandom_range(1) : ($urandom_range(9) == 0),
                $urandom_range(3) == 0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        int n;
        int added;
        bit paused;
        logic [LIMIT_W-1:0] limit;

        restart_stream();
        out_limit = '0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, with the sender mostly busy and the receiver mostly idle.
        send_gap_pct = 9;
        recv_gap_pct = 77;

        // Straight out of reset the limit is zero and no stream was started:
        // the first item finishes the stream with a status-only result, and the
        // next one is ignored.
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b1);
        wait_idle();

        // Largest limit. Literals at both byte extremes, a longest match from the
        // highest position that wraps round the ring, a shortest match from
        // position one, a literal, then the end marker; a byte after it is ignored.
        set_limit(LIMIT_MAX);
        bit_q.delete();
        put_literal(8'hFF);
        put_literal(8'h00);
        put_match(HIST_DEPTH - 1, MATCH_MAX);
        put_match(1, 0);
        put_literal(8'hA5);
        put_end_marker();
        flush_stream(1'b0, n);
        queue_item(8'h5A, 1'b0, 1'b0);
        // A partial literal cut off by the input end gives only a status result.
        queue_item(8'h80, 1'b1, 1'b1);
        // A long match on a fresh ring reads cleared entries, then the input ends
        // in the middle of the next token.
        bit_q.delete();
        put_match(1, MATCH_MAX);
        flush_stream(1'b1, n);
        wait_idle();

        // Small limit: a match running past it is truncated inside the item, and
        // the following byte is ignored.
        set_limit(LIMIT_W'(5));
        bit_q.delete();
        put_literal(8'h3C);
        put_match(1, MATCH_MAX);
        put_literal(8'hC3);
        flush_stream(1'b0, n);
        queue_item(8'h7E, 1'b0, 1'b0);
        wait_idle();

        // Random part: three pacing modes, each with three limit settings.
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_gap_pct = 9;
                    recv_gap_pct = 77;
                end
                1:
                begin
                    send_gap_pct = 77;
                    recv_gap_pct = 9;
                end
                default:
                begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end
            endcase
            for (int sub = 0; sub < 3; sub++)
            begin
                case (sub)
                    0: limit = LIMIT_MAX;
                    1: limit = LIMIT_W'($urandom_range(60, 1));
                    default: limit = (mode == 2) ? '0 : LIMIT_W'($urandom_range(200, 8));
                endcase
                set_limit(limit);
                added  = 0;
                paused = 1'b0;
                while (added < ITEMS_PER_SETTING)
                begin
                    if ($urandom_range(99) < 15)
                        queue_noise(n);
                    else
                        queue_random_stream(n);
                    added += n;
                    // Back up the decoder once with a long output hold while
                    // the input side keeps pushing.
                    if (mode == 0 && sub == 0 && hold_asked == 0)
                        hold_asked++;
                    // Halfway through, let the sender wait for every result.
                    if (!paused && added >= PAUSE_AFTER)
                    begin
                        paused = 1'b1;
                        wait_idle();
                    end
                end
                wait_idle();
            end
        end

        $display("Decoded %0d compressed items in %0d streams into %0d result items,",
            items_taken, streams_seen, results_seen);
        $display("over limits from zero to full scale and three handshake pacing modes.");
        if (error_count == 0)
            $display("lzss_bit_stream_decoder_top: match");
        else
            $display("lzss_bit_stream_decoder_top: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lzsbd_pkg.sv
rtl/lzsbd_ram.sv
rtl/lzsbd_out.sv
rtl/lzsbd_core.sv
rtl/lzss_bit_stream_decoder_top.sv
test/tb_lzss_bit_stream_decoder_top.sv
